[hw/rtl/docking_pair_energy_term_unit_assert.svh]
// Assertion macros shared by the pair energy term RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef DOCKING_PAIR_ENERGY_TERM_UNIT_ASSERT_SVH
`define DOCKING_PAIR_ENERGY_TERM_UNIT_ASSERT_SVH

// Plain property check.
`define DPET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a result in the next.
`define DPET_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/dpet_pkg.sv]
package dpet_pkg;

  // Pipeline depth in register stages, input register to output register.
  localparam int PIPE_DEPTH = 8;

  // Exp table index at or above which the Gaussian is zero.
  localparam logic [7:0] GAUSS_Q_LIMIT = 8'd192;

  // Configuration register indexes.
  localparam logic [2:0] CFG_GAUSS_NEAR  = 3'd0;
  localparam logic [2:0] CFG_GAUSS_FAR   = 3'd1;
  localparam logic [2:0] CFG_REPULSION   = 3'd2;
  localparam logic [2:0] CFG_HBOND       = 3'd3;
  localparam logic [2:0] CFG_HYDROPHOBIC = 3'd4;

  // Reset weights, Q16.
  localparam logic signed [17:0] RST_GAUSS_NEAR  = -18'sd2332;
  localparam logic signed [17:0] RST_GAUSS_FAR   = -18'sd338;
  localparam logic signed [17:0] RST_REPULSION   = 18'sd55066;
  localparam logic signed [17:0] RST_HBOND       = -18'sd38498;
  localparam logic signed [17:0] RST_HYDROPHOBIC = -18'sd2298;

  // Hydrogen bond kind codes: donors are codes 1 and 2, acceptors from ACC_LO up.
  localparam logic [2:0] HB_DONOR_LO = 3'd1;
  localparam logic [2:0] HB_DONOR_HI = 3'd2;
  localparam logic [2:0] HB_ACC_LO   = 3'd3;

  typedef struct packed {
    logic signed [17:0] gauss_near;
    logic signed [17:0] gauss_far;
    logic signed [17:0] repulsion;
    logic signed [17:0] hbond;
    logic signed [17:0] hydrophobic;
  } dpet_weights_t;

  // Per-stage load strobes, stage 1 at the input.
  typedef logic [PIPE_DEPTH:1] dpet_load_t;

  // exp(-n) in Q16 for integer n.
  function automatic logic [16:0] exp_int(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-f/16) in Q16 for f = 0..15.
  function automatic logic [16:0] exp_frac(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32953;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/dpet_cfg_regs.sv]
module dpet_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [2:0]             cfg_index_i,
  input  logic [17:0]            cfg_data_i,
  output dpet_pkg::dpet_weights_t weights_o
);
  import dpet_pkg::*;

  dpet_weights_t weights_d, weights_q;

  // Register write decode; unknown indexes are dropped.
  always_comb begin
    weights_d = weights_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAUSS_NEAR:  weights_d.gauss_near  = $signed(cfg_data_i);
        CFG_GAUSS_FAR:   weights_d.gauss_far   = $signed(cfg_data_i);
        CFG_REPULSION:   weights_d.repulsion   = $signed(cfg_data_i);
        CFG_HBOND:       weights_d.hbond       = $signed(cfg_data_i);
        CFG_HYDROPHOBIC: weights_d.hydrophobic = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.gauss_near  <= RST_GAUSS_NEAR;
      weights_q.gauss_far   <= RST_GAUSS_FAR;
      weights_q.repulsion   <= RST_REPULSION;
      weights_q.hbond       <= RST_HBOND;
      weights_q.hydrophobic <= RST_HYDROPHOBIC;
    end else begin
      weights_q <= weights_d;
    end
  end

  assign weights_o = weights_q;

endmodule

[hw/rtl/dpet_gauss_lane.sv]
module dpet_gauss_lane (
  input  logic                   clk_i,
  input  dpet_pkg::dpet_load_t   load_i,
  input  logic [7:0]             q_i,
  input  logic signed [17:0]     weight_i,
  output logic signed [18:0]     term_o
);
  import dpet_pkg::*;

  logic [33:0]        p4_d, p4_q;
  logic [33:0]        g_sum5;
  logic [16:0]        g5;
  logic signed [34:0] wg5_d, wg5_q;
  logic signed [35:0] s6;
  logic signed [18:0] term6_d, term6_q;

  // Stage 4: table product, zero past the table end.
  assign p4_d = (q_i >= GAUSS_Q_LIMIT) ? 34'd0 :
                {17'd0, exp_int(q_i[7:4])} * {17'd0, exp_frac(q_i[3:0])};

  // Stage 5: round to Q16, then weight.
  assign g_sum5 = p4_q + 34'd32768;
  assign g5     = g_sum5[32:16];
  assign wg5_d  = 35'(weight_i) * 35'($signed({1'b0, g5}));

  // Stage 6: round the weighted term back to Q16.
  assign s6      = 36'(wg5_q) + 36'sd32768;
  assign term6_d = s6[34:16];

  always_ff @(posedge clk_i) begin
    if (load_i[4]) p4_q    <= p4_d;
    if (load_i[5]) wg5_q   <= wg5_d;
    if (load_i[6]) term6_q <= term6_d;
  end

  assign term_o = term6_q;

endmodule

[hw/rtl/dpet_rep_lane.sv]
module dpet_rep_lane (
  input  logic                   clk_i,
  input  dpet_pkg::dpet_load_t   load_i,
  input  logic [19:0]            rsq_i,
  input  logic signed [17:0]     weight_i,
  output logic signed [25:0]     term_o
);
  import dpet_pkg::*;

  // 2^35/10000 rounded up, exact for 20-bit squares.
  localparam logic [41:0] RecipSq  = 42'd3435974;
  // 2^31/10000 rounded down, estimate low by at most one.
  localparam logic [48:0] RecipEst = 49'd214748;

  logic [41:0]        pa3;
  logic [6:0]         a3_d, a3_q;
  logic [19:0]        rsq3_q;
  logic [19:0]        b_full4;
  logic [13:0]        b4_d, b4_q;
  logic signed [25:0] wa4_d, wa4_q, wa5_q, wa6_q;
  logic signed [32:0] t5_d, t5_q;
  logic               neg6_d, neg6_q;
  logic [30:0]        u6_d, u6_q;
  logic [48:0]        pq6;
  logic [17:0]        q0_6_d, q0_6_q;
  logic [30:0]        r7;
  logic [17:0]        q7;
  logic signed [18:0] qs7;
  logic signed [25:0] term7_d, term7_q;

  // Stage 3: split the square as a*10000 + b.
  assign pa3  = {22'd0, rsq_i} * RecipSq;
  assign a3_d = pa3[41:35];

  // Stage 4: remainder b and the whole-part term w*a.
  assign b_full4 = rsq3_q - ({13'd0, a3_q} * 20'd10000);
  assign b4_d    = b_full4[13:0];
  assign wa4_d   = 26'(weight_i) * 26'($signed({1'b0, a3_q}));

  // Stage 5: w*b plus half the divisor.
  assign t5_d = 33'(weight_i) * 33'($signed({1'b0, b4_q})) + 33'sd5000;

  // Stage 6: fold sign for floor division, estimate quotient.
  assign neg6_d = t5_q[32];
  assign u6_d   = neg6_d ? 31'(-t5_q + 33'sd9999) : 31'(t5_q);
  assign pq6    = {18'd0, u6_d} * RecipEst;
  assign q0_6_d = pq6[48:31];

  // Stage 7: one correction step, restore sign, add whole part.
  assign r7      = u6_q - ({13'd0, q0_6_q} * 31'd10000);
  assign q7      = q0_6_q + {17'd0, (r7 >= 31'd10000)};
  assign qs7     = $signed({1'b0, q7});
  assign term7_d = wa6_q + (neg6_q ? -26'(qs7) : 26'(qs7));

  always_ff @(posedge clk_i) begin
    if (load_i[3]) begin
      a3_q   <= a3_d;
      rsq3_q <= rsq_i;
    end
    if (load_i[4]) begin
      b4_q  <= b4_d;
      wa4_q <= wa4_d;
    end
    if (load_i[5]) begin
      t5_q  <= t5_d;
      wa5_q <= wa4_q;
    end
    if (load_i[6]) begin
      neg6_q <= neg6_d;
      u6_q   <= u6_d;
      q0_6_q <= q0_6_d;
      wa6_q  <= wa5_q;
    end
    if (load_i[7]) term7_q <= term7_d;
  end

  assign term_o = term7_q;

endmodule

[hw/rtl/docking_pair_energy_term_unit.sv]
// Pair energy term unit: one energy increment per (type pair, distance) beat.
// Input channel (in_valid_i/in_ready_o) carries the distance index, both
// radii, both hydrogen bond kinds and both carbon flags. Output channel
// (out_valid_o/out_ready_i) carries the saturated Q16 energy_delta.
// Config channel (cfg_valid_i/cfg_ready_o) writes the five Q16 weights;
// it is always ready and should be used only while the pipe is empty.
// From input beat to output valid a beat passes the eight register stages
// (gap, squares, reciprocal divides, exp table, weighting, rounding,
// repulsion correction, sum and saturate).
// Throughput: one beat per cycle; each stage advances on its own ready, so
// bubbles close up while the output stalls and the unit keeps taking beats
// until the pipe is full. A stalled output holds its beat unchanged.
// Reset clears all stage valid bits and loads the default weights.
`include "docking_pair_energy_term_unit_assert.svh"

module docking_pair_energy_term_unit #(
  parameter int DISTANCE_STEPS = 2048
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [10:0]        distance_index_i,
  input  logic [8:0]         ligand_radius_i,
  input  logic [8:0]         receptor_radius_i,
  input  logic [2:0]         ligand_hbond_kind_i,
  input  logic [2:0]         receptor_hbond_kind_i,
  input  logic               ligand_is_carbon_i,
  input  logic               receptor_is_carbon_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] energy_delta_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i
);
  import dpet_pkg::*;

  localparam logic [14:0] DistSteps = 15'(DISTANCE_STEPS);
  // Reciprocals: 2^28/625, 2^32/2500 rounded up; 2^31/70, 2^31/100 rounded up.
  localparam logic [36:0] RecipNear = 37'd429497;
  localparam logic [40:0] RecipFar  = 41'd1717987;
  localparam logic [48:0] RecipHb   = 49'd30678338;
  localparam logic [48:0] RecipHp   = 49'd21474837;

  dpet_weights_t weights;
  dpet_load_t    load;
  dpet_load_t    valid_q;

  // Stage 1
  logic signed [11:0] d1_d, d1_q;
  logic               oob1_d, oob1_q;
  logic               ldon, lacc, rdon, racc;
  logic               hb1_d, hb1_q, hp1_d, hp1_q;
  // Stage 2
  logic [10:0]        dabs2;
  logic signed [12:0] e2;
  logic [11:0]        eabs2;
  logic [15:0]        nsq2_d, nsq2_q;
  logic [19:0]        fsq2_d, fsq2_q, rsq2_d, rsq2_q;
  logic               near_z2_d, near_z2_q, far_z2_d, far_z2_q;
  logic               hb_full2_d, hb_full2_q, hb_ramp2_d, hb_ramp2_q;
  logic               hp_full2_d, hp_full2_q, hp_ramp2_d, hp_ramp2_q;
  logic [6:0]         m_hb2, m_hp2;
  logic signed [11:0] hp_m12;
  logic signed [25:0] hb_t2_d, hb_t2_q, hp_t2_d, hp_t2_q;
  logic               oob2_q;
  // Stage 3
  logic [17:0]        nn3;
  logic [36:0]        pn3;
  logic [19:0]        nf3;
  logic [40:0]        pf3;
  logic [7:0]         qn3_d, qn3_q, qf3_d, qf3_q;
  logic [23:0]        hb_u3, hp_u3;
  logic [48:0]        phb3, php3;
  logic [17:0]        hbq3_d, hbq3_q, hpq3_d, hpq3_q;
  logic               hb_neg3_q, hp_neg3_q;
  logic               hb_full3_q, hb_ramp3_q, hp_full3_q, hp_ramp3_q;
  logic               oob3_q;
  // Stage 4 through 7
  logic signed [18:0] hbqs4, hpqs4, hb_term4, hp_term4;
  logic signed [19:0] slope4_d, slope4_q, slope5_q, slope6_q, slope7_q;
  logic               oob4_q, oob5_q, oob6_q, oob7_q;
  logic signed [18:0] near6, far6, near7_q, far7_q;
  logic signed [25:0] rep7;
  // Stage 8
  logic signed [26:0] sum8;
  logic signed [23:0] energy8_d, energy8_q;

  dpet_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .weights_o   (weights)
  );

  assign cfg_ready_o = 1'b1;

  // Per-stage ready chain from the output back to the input.
  always_comb begin
    load[PIPE_DEPTH] = !valid_q[PIPE_DEPTH] || out_ready_i;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      load[k] = !valid_q[k] || load[k + 1];
    end
  end

  assign in_ready_o = load[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (load[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (load[k]) valid_q[k] <= valid_q[k - 1];
      end
    end
  end

  // Stage 1: surface gap and pair class.
  assign d1_d   = $signed({1'b0, distance_index_i}) - $signed({3'b000, ligand_radius_i})
                - $signed({3'b000, receptor_radius_i});
  assign oob1_d = {4'd0, distance_index_i} >= DistSteps;
  assign ldon   = (ligand_hbond_kind_i == HB_DONOR_LO) || (ligand_hbond_kind_i == HB_DONOR_HI);
  assign lacc   = ligand_hbond_kind_i >= HB_ACC_LO;
  assign rdon   = (receptor_hbond_kind_i == HB_DONOR_LO) ||
                  (receptor_hbond_kind_i == HB_DONOR_HI);
  assign racc   = receptor_hbond_kind_i >= HB_ACC_LO;
  assign hb1_d  = (ldon && racc) || (lacc && rdon);
  assign hp1_d  = ligand_is_carbon_i && receptor_is_carbon_i;

  // Stage 2: squares for the Gaussians and repulsion, slope products.
  assign dabs2     = d1_q[11] ? 11'(-d1_q) : 11'(d1_q);
  assign near_z2_d = dabs2 >= 11'd174;
  assign nsq2_d    = {8'd0, dabs2[7:0]} * {8'd0, dabs2[7:0]};
  assign e2        = $signed({d1_q[11], d1_q}) - 13'sd300;
  assign eabs2     = e2[12] ? 12'(-e2) : 12'(e2);
  assign far_z2_d  = eabs2 >= 12'd693;
  assign fsq2_d    = {10'd0, eabs2[9:0]} * {10'd0, eabs2[9:0]};
  assign rsq2_d    = d1_q[11] ? {10'd0, dabs2[9:0]} * {10'd0, dabs2[9:0]} : 20'd0;

  assign hb_full2_d = hb1_q && (d1_q <= -12'sd70);
  assign hb_ramp2_d = hb1_q && d1_q[11] && (d1_q > -12'sd70);
  assign m_hb2      = hb_ramp2_d ? dabs2[6:0] : 7'd0;
  assign hb_t2_d    = 26'(weights.hbond) * 26'($signed({1'b0, m_hb2})) + 26'sd35;

  assign hp_full2_d = hp1_q && (d1_q <= 12'sd50);
  assign hp_ramp2_d = hp1_q && (d1_q > 12'sd50) && (d1_q < 12'sd150);
  assign hp_m12     = 12'sd150 - d1_q;
  assign m_hp2      = hp_ramp2_d ? hp_m12[6:0] : 7'd0;
  assign hp_t2_d    = 26'(weights.hydrophobic) * 26'($signed({1'b0, m_hp2})) + 26'sd50;

  // Stage 3: table indexes and slope quotients by reciprocal multiply.
  assign nn3   = {nsq2_q, 2'b00} + 18'd312;
  assign pn3   = {19'd0, nn3} * RecipNear;
  assign qn3_d = near_z2_q ? GAUSS_Q_LIMIT : pn3[35:28];
  assign nf3   = fsq2_q + 20'd1250;
  assign pf3   = {21'd0, nf3} * RecipFar;
  assign qf3_d = far_z2_q ? GAUSS_Q_LIMIT : pf3[39:32];

  assign hb_u3  = hb_t2_q[25] ? 24'(-hb_t2_q + 26'sd69) : 24'(hb_t2_q);
  assign phb3   = {25'd0, hb_u3} * RecipHb;
  assign hbq3_d = phb3[48:31];
  assign hp_u3  = hp_t2_q[25] ? 24'(-hp_t2_q + 26'sd99) : 24'(hp_t2_q);
  assign php3   = {25'd0, hp_u3} * RecipHp;
  assign hpq3_d = php3[48:31];

  // Stage 4: slope terms with sign restored, then their sum.
  assign hbqs4    = $signed({1'b0, hbq3_q});
  assign hpqs4    = $signed({1'b0, hpq3_q});
  assign hb_term4 = hb_full3_q ? 19'(weights.hbond) :
                    hb_ramp3_q ? (hb_neg3_q ? -hbqs4 : hbqs4) : 19'sd0;
  assign hp_term4 = hp_full3_q ? 19'(weights.hydrophobic) :
                    hp_ramp3_q ? (hp_neg3_q ? -hpqs4 : hpqs4) : 19'sd0;
  assign slope4_d = 20'(hb_term4) + 20'(hp_term4);

  dpet_gauss_lane u_gauss_near (
    .clk_i    (clk_i),
    .load_i   (load),
    .q_i      (qn3_q),
    .weight_i (weights.gauss_near),
    .term_o   (near6)
  );

  dpet_gauss_lane u_gauss_far (
    .clk_i    (clk_i),
    .load_i   (load),
    .q_i      (qf3_q),
    .weight_i (weights.gauss_far),
    .term_o   (far6)
  );

  dpet_rep_lane u_rep (
    .clk_i    (clk_i),
    .load_i   (load),
    .rsq_i    (rsq2_q),
    .weight_i (weights.repulsion),
    .term_o   (rep7)
  );

  // Stage 8: sum of five terms, saturate, zero past the table.
  assign sum8 = 27'(near7_q) + 27'(far7_q) + 27'(rep7) + 27'(slope7_q);
  always_comb begin
    if (oob7_q) begin
      energy8_d = 24'sd0;
    end else if (sum8 > 27'sd8388607) begin
      energy8_d = 24'sd8388607;
    end else if (sum8 < -27'sd8388608) begin
      energy8_d = -24'sd8388608;
    end else begin
      energy8_d = 24'(sum8);
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      d1_q   <= d1_d;
      oob1_q <= oob1_d;
      hb1_q  <= hb1_d;
      hp1_q  <= hp1_d;
    end
    if (load[2]) begin
      nsq2_q     <= nsq2_d;
      fsq2_q     <= fsq2_d;
      rsq2_q     <= rsq2_d;
      near_z2_q  <= near_z2_d;
      far_z2_q   <= far_z2_d;
      hb_full2_q <= hb_full2_d;
      hb_ramp2_q <= hb_ramp2_d;
      hp_full2_q <= hp_full2_d;
      hp_ramp2_q <= hp_ramp2_d;
      hb_t2_q    <= hb_t2_d;
      hp_t2_q    <= hp_t2_d;
      oob2_q     <= oob1_q;
    end
    if (load[3]) begin
      qn3_q      <= qn3_d;
      qf3_q      <= qf3_d;
      hbq3_q     <= hbq3_d;
      hpq3_q     <= hpq3_d;
      hb_neg3_q  <= hb_t2_q[25];
      hp_neg3_q  <= hp_t2_q[25];
      hb_full3_q <= hb_full2_q;
      hb_ramp3_q <= hb_ramp2_q;
      hp_full3_q <= hp_full2_q;
      hp_ramp3_q <= hp_ramp2_q;
      oob3_q     <= oob2_q;
    end
    if (load[4]) begin
      slope4_q <= slope4_d;
      oob4_q   <= oob3_q;
    end
    if (load[5]) begin
      slope5_q <= slope4_q;
      oob5_q   <= oob4_q;
    end
    if (load[6]) begin
      slope6_q <= slope5_q;
      oob6_q   <= oob5_q;
    end
    if (load[7]) begin
      slope7_q <= slope6_q;
      oob7_q   <= oob6_q;
      near7_q  <= near6;
      far7_q   <= far6;
    end
    if (load[8]) energy8_q <= energy8_d;
  end

  assign out_valid_o    = valid_q[PIPE_DEPTH];
  assign energy_delta_o = energy8_q;

  // An empty output stage means every stage can advance.
  `DPET_ASSERT(a_empty_out_ready, !out_valid_o |-> in_ready_o, "input stalled with output empty")
  // An accepted input beat lands in stage one.
  `DPET_ASSERT_NEXT(a_accept_lands, in_valid_i && in_ready_o, valid_q[1], "accepted beat lost")
  // A blocked middle stage keeps its beat and payload.
  `DPET_ASSERT_NEXT(a_stage4_hold, valid_q[4] && !load[4], valid_q[4] && $stable(slope4_q),
                    "blocked stage lost its beat")
  // A beat moving out of stage seven reaches the output.
  `DPET_ASSERT_NEXT(a_last_move, valid_q[7] && load[8], out_valid_o, "beat lost before output")

endmodule

[verif/docking_pair_energy_term_unit_tb.sv]
`timescale 1ns / 100ps

module docking_pair_energy_term_unit_tb;
  import dpet_pkg::*;

  localparam int DIST_STEPS = 2048;
  localparam int NUM_WEIGHTS = 5;
  localparam int PHASES = 7;
  localparam int RANDOM_PER_PHASE = 130;
  localparam logic signed [17:0] WEIGHT_MAX = 18'sh1FFFF;
  localparam logic signed [17:0] WEIGHT_MIN = -18'sh20000;

  typedef struct packed {
    logic [10:0] dist_idx;
    logic [8:0]  lig_rad;
    logic [8:0]  rec_rad;
    logic [2:0]  lig_kind;
    logic [2:0]  rec_kind;
    logic        lig_carbon;
    logic        rec_carbon;
  } pair_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [10:0]        distance_index_i = '0;
  logic [8:0]         ligand_radius_i = '0;
  logic [8:0]         receptor_radius_i = '0;
  logic [2:0]         ligand_hbond_kind_i = '0;
  logic [2:0]         receptor_hbond_kind_i = '0;
  logic               ligand_is_carbon_i = 1'b0;
  logic               receptor_is_carbon_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [23:0] energy_delta_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [17:0]        cfg_data_i = '0;

  // Predictor state: the weight copy, pair backlog and energies in flight
  logic signed [17:0]  model_weight [NUM_WEIGHTS];
  pair_item_t          pending_pairs [$];
  logic signed [23:0]  expected_energy [$];
  pair_item_t          cur_pair;
  int                  pairs_queued = 0;
  int                  pairs_accepted = 0;
  int                  error_count = 0;
  int                  send_gap = 0;
  int                  send_burst = 0;
  int                  recv_stall = 0;
  int                  recv_burst = 0;

  docking_pair_energy_term_unit #(
    .DISTANCE_STEPS(DIST_STEPS)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .distance_index_i     (distance_index_i),
    .ligand_radius_i      (ligand_radius_i),
    .receptor_radius_i    (receptor_radius_i),
    .ligand_hbond_kind_i  (ligand_hbond_kind_i),
    .receptor_hbond_kind_i(receptor_hbond_kind_i),
    .ligand_is_carbon_i   (ligand_is_carbon_i),
    .receptor_is_carbon_i (receptor_is_carbon_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .energy_delta_o       (energy_delta_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  // Idle length: mostly none or short, a few long, and now and then a clean burst
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      burst = $urandom_range(80, 30);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  // Half-up rounding of num / den, den > 0, floor semantics for negatives
  function automatic longint div_round(longint num, longint den);
    longint n;
    longint quo;
    n = num + den / 2;
    quo = n / den;
    if ((n % den) != 0 && n < 0) quo--;
    return quo;
  endfunction

  // exp(-q/16) in Q16: whole part times fractional part, rounded
  function automatic longint gauss_q16(longint q);
    longint whole;
    longint frac;
    if (q < 0 || q >= longint'(GAUSS_Q_LIMIT)) return 0;
    case (q / 16)
      0: whole = 65536;
      1: whole = 24109;
      2: whole = 8869;
      3: whole = 3263;
      4: whole = 1200;
      5: whole = 442;
      6: whole = 162;
      7: whole = 60;
      8: whole = 22;
      9: whole = 8;
      10: whole = 3;
      default: whole = 1;
    endcase
    case (q % 16)
      0: frac = 65536;
      1: frac = 61565;
      2: frac = 57835;
      3: frac = 54331;
      4: frac = 51039;
      5: frac = 47947;
      6: frac = 45042;
      7: frac = 42313;
      8: frac = 39750;
      9: frac = 37341;
      10: frac = 35079;
      11: frac = 32953;
      12: frac = 30957;
      13: frac = 29081;
      14: frac = 27319;
      default: frac = 25664;
    endcase
    return (whole * frac + 32768) >>> 16;
  endfunction

  // Energy increment of one pair beat under the current weights
  function automatic logic signed [23:0] predict_energy(pair_item_t p);
    longint gap;
    longint off;
    longint sum;
    longint w;
    bit     lig_don, lig_acc, rec_don, rec_acc;
    sum = 0;
    if (int'(p.dist_idx) < DIST_STEPS) begin
      gap = longint'(p.dist_idx) - longint'(p.lig_rad) - longint'(p.rec_rad);
      lig_don = p.lig_kind >= HB_DONOR_LO && p.lig_kind <= HB_DONOR_HI;
      lig_acc = p.lig_kind >= HB_ACC_LO;
      rec_don = p.rec_kind >= HB_DONOR_LO && p.rec_kind <= HB_DONOR_HI;
      rec_acc = p.rec_kind >= HB_ACC_LO;

      // two Gaussians
      w = longint'(model_weight[CFG_GAUSS_NEAR]);
      sum += div_round(w * gauss_q16((4 * gap * gap + 312) / 625), 65536);
      off = gap - 300;
      w = longint'(model_weight[CFG_GAUSS_FAR]);
      sum += div_round(w * gauss_q16((off * off + 1250) / 2500), 65536);

      // overlap repulsion
      if (gap < 0) begin
        w = longint'(model_weight[CFG_REPULSION]);
        sum += div_round(w * gap * gap, 10000);
      end

      // donor/acceptor slope step
      if ((lig_don && rec_acc) || (lig_acc && rec_don)) begin
        w = longint'(model_weight[CFG_HBOND]);
        if (gap <= -70) sum += w;
        else if (gap < 0) sum += div_round(w * (-gap), 70);
      end

      // carbon/carbon slope step
      if (p.lig_carbon && p.rec_carbon) begin
        w = longint'(model_weight[CFG_HYDROPHOBIC]);
        if (gap <= 50) sum += w;
        else if (gap < 150) sum += div_round(w * (150 - gap), 100);
      end
    end
    if (sum > 8388607) sum = 8388607;
    if (sum < -8388608) sum = -8388608;
    return 24'(sum);
  endfunction

  // Input driver: predicts on each accepted beat, then loads the next pair
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_energy.push_back(predict_energy(cur_pair));
        pairs_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 || pending_pairs.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          cur_pair = pending_pairs.pop_front();
          distance_index_i      <= cur_pair.dist_idx;
          ligand_radius_i       <= cur_pair.lig_rad;
          receptor_radius_i     <= cur_pair.rec_rad;
          ligand_hbond_kind_i   <= cur_pair.lig_kind;
          receptor_hbond_kind_i <= cur_pair.rec_kind;
          ligand_is_carbon_i    <= cur_pair.lig_carbon;
          receptor_is_carbon_i  <= cur_pair.rec_carbon;
          in_valid_i <= 1'b1;
          send_gap = pick_gap(send_burst);
        end
      end
    end
  end

  // Output monitor with random back-pressure
  always @(posedge clk_i) begin
    logic signed [23:0] want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_energy.size() == 0) begin
          $error("energy_delta: no beat expected, got %0d", energy_delta_o);
          error_count++;
        end else begin
          want = expected_energy.pop_front();
          if (energy_delta_o !== want) begin
            $error("energy_delta: expected %0d, got %0d", want, energy_delta_o);
            error_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall = pick_gap(recv_burst);
      end
    end
  end

  // One register write beat; the model copy follows at the handshake
  task automatic write_weight(input logic [2:0] idx, input logic [17:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (int'(idx) < NUM_WEIGHTS) model_weight[idx] = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_weights(input logic signed [17:0] near, input logic signed [17:0] far,
                              input logic signed [17:0] rep, input logic signed [17:0] hb,
                              input logic signed [17:0] hyd);
    write_weight(CFG_GAUSS_NEAR, near);
    write_weight(CFG_GAUSS_FAR, far);
    write_weight(CFG_REPULSION, rep);
    write_weight(CFG_HBOND, hb);
    write_weight(CFG_HYDROPHOBIC, hyd);
    // unmapped index, must leave every weight alone
    write_weight(3'(NUM_WEIGHTS + $urandom_range(7 - NUM_WEIGHTS)), 18'($urandom));
  endtask

  function automatic pair_item_t mk_pair(int idx, int lr, int rr, int lk, int rk,
                                         int lc, int rc);
    pair_item_t p;
    p.dist_idx   = 11'(idx);
    p.lig_rad    = 9'(lr);
    p.rec_rad    = 9'(rr);
    p.lig_kind   = 3'(lk);
    p.rec_kind   = 3'(rk);
    p.lig_carbon = 1'(lc);
    p.rec_carbon = 1'(rc);
    return p;
  endfunction

  // Mostly gaps near the interesting range, the rest fully random fields
  function automatic pair_item_t random_pair();
    pair_item_t p;
    int gap;
    int idx;
    p = mk_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(9) < 7) begin
      p.lig_rad = 9'($urandom_range(9) == 0 ? $urandom_range(511) : $urandom_range(400));
      p.rec_rad = 9'($urandom_range(9) == 0 ? $urandom_range(511) : $urandom_range(400));
      gap = int'($urandom_range(900)) - 300;
      idx = int'(p.lig_rad) + int'(p.rec_rad) + gap;
      if (idx < 0) idx = 0;
      if (idx > DIST_STEPS - 1) idx = DIST_STEPS - 1;
      p.dist_idx = 11'(idx);
    end
    return p;
  endfunction

  task automatic queue_pair(input pair_item_t p);
    pending_pairs.push_back(p);
    pairs_queued++;
  endtask

  // Field extremes, slope-step edges, every kind pairing
  task automatic queue_directed();
    queue_pair(mk_pair(0, 0, 0, 0, 0, 0, 0));        // index zero
    queue_pair(mk_pair(2047, 0, 0, 0, 0, 1, 1));     // top index
    queue_pair(mk_pair(1, 511, 511, 1, 3, 1, 1));    // radii above range, deep overlap
    queue_pair(mk_pair(2047, 511, 511, 7, 2, 0, 1));
    queue_pair(mk_pair(230, 150, 150, 1, 3, 0, 0));  // hbond full step edge
    queue_pair(mk_pair(231, 150, 150, 2, 7, 0, 0));
    queue_pair(mk_pair(299, 150, 150, 3, 1, 0, 0));
    queue_pair(mk_pair(300, 150, 150, 7, 2, 0, 0));  // hbond off at contact
    queue_pair(mk_pair(270, 150, 150, 0, 5, 0, 0));  // no donor
    queue_pair(mk_pair(270, 150, 150, 1, 2, 0, 0));  // donor pair
    queue_pair(mk_pair(270, 150, 150, 4, 6, 0, 0));  // acceptor pair
    queue_pair(mk_pair(350, 150, 150, 0, 0, 1, 1));  // hydrophobic full step edge
    queue_pair(mk_pair(351, 150, 150, 0, 0, 1, 1));
    queue_pair(mk_pair(449, 150, 150, 0, 0, 1, 1));
    queue_pair(mk_pair(450, 150, 150, 0, 0, 1, 1));  // hydrophobic off
    queue_pair(mk_pair(360, 150, 150, 0, 0, 1, 0));
    queue_pair(mk_pair(360, 150, 150, 0, 0, 0, 1));
    queue_pair(mk_pair(600, 150, 150, 0, 0, 0, 0));  // far Gaussian peak
    queue_pair(mk_pair(300, 200, 100, 0, 0, 0, 0));  // near Gaussian peak
    queue_pair(mk_pair(1024, 256, 256, 6, 1, 1, 1));
    queue_pair(mk_pair(5, 400, 400, 2, 4, 1, 1));
  endtask

  task automatic wait_drained();
    while (pairs_accepted != pairs_queued || expected_energy.size() != 0)
      @(posedge clk_i);
  endtask

  // Sequence: reset, then phases of weights and pairs, draining in between
  initial begin
    model_weight[CFG_GAUSS_NEAR]  = RST_GAUSS_NEAR;
    model_weight[CFG_GAUSS_FAR]   = RST_GAUSS_FAR;
    model_weight[CFG_REPULSION]   = RST_REPULSION;
    model_weight[CFG_HBOND]       = RST_HBOND;
    model_weight[CFG_HYDROPHOBIC] = RST_HYDROPHOBIC;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) load_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX);
      else if (ph == 2)
        load_weights(WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN, WEIGHT_MIN);
      else if (ph == 3) load_weights('0, '0, '0, '0, '0);
      else if (ph > 3)
        load_weights(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
                     18'($urandom));
      queue_directed();
      for (int k = 0; k < RANDOM_PER_PHASE; k++) queue_pair(random_pair());
      // sender holds off until the pipe has fully drained
      wait_drained();
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/dpet_pkg.sv
hw/rtl/dpet_cfg_regs.sv
hw/rtl/dpet_gauss_lane.sv
hw/rtl/dpet_rep_lane.sv
hw/rtl/docking_pair_energy_term_unit.sv
verif/docking_pair_energy_term_unit_tb.sv
